### rtl/core/srb_pkg.sv
// shared types and constants for the scheduled relay bank
// no dependencies; used by srb_bank, scheduled_relay_bank and the testbench
package srb_pkg;

    // addressable channels: relay_index is three bits wide
    localparam int ADDR_W    = 3;
    localparam int MAX_ADDR  = 8;
    localparam int TIME_W    = 32;
    localparam int KIND_W    = 2;
    localparam int PIN_W     = 8;

    localparam logic [TIME_W-1:0] NO_DUE = '1;

    // action codes
    localparam logic [2:0] ACT_SET      = 3'd0;
    localparam logic [2:0] ACT_TOGGLE   = 3'd1;
    localparam logic [2:0] ACT_SCHEDULE = 3'd2;
    localparam logic [2:0] ACT_CANCEL   = 3'd3;
    localparam logic [2:0] ACT_TICK     = 3'd4;
    localparam logic [2:0] ACT_POWER    = 3'd5;
    localparam logic [2:0] ACT_QUERY    = 3'd6;

    // pending change kinds, any other value toggles
    localparam logic [KIND_W-1:0] CHANGE_OFF = 2'd0;
    localparam logic [KIND_W-1:0] CHANGE_ON  = 2'd1;

    typedef struct packed {
        logic [2:0]        action;
        logic [ADDR_W-1:0] relay_index;
        logic              level;
        logic [TIME_W-1:0] time_value;
        logic [KIND_W-1:0] change_kind;
    } req_item_t;

    typedef struct packed {
        logic              accepted;
        logic              queried_level;
        logic [TIME_W-1:0] queried_due_time;
        logic [KIND_W-1:0] queried_change;
        logic [PIN_W-1:0]  pin_levels;
        logic              power_is_off;
    } rsp_item_t;

    // operations on the channel store
    typedef enum logic [2:0] {
        OP_NONE,
        OP_SET,
        OP_TOGGLE,
        OP_SCHEDULE,
        OP_CANCEL,
        OP_SCAN,
        OP_POWER
    } bank_op_e_t;

    typedef struct packed {
        bank_op_e_t        op;
        logic [ADDR_W-1:0] idx;
        logic              level;
        logic [TIME_W-1:0] time_value;
        logic [KIND_W-1:0] kind;
    } bank_op_t;

    typedef struct packed {
        logic              level;
        logic [TIME_W-1:0] due_time;
        logic [KIND_W-1:0] change;
        logic [PIN_W-1:0]  pins;
        logic              master_off;
    } bank_rd_t;

endpackage

### rtl/core/srb_chan_if.sv
// valid/ready channel carrying one item of a given payload type
// depends on nothing; payload types come from srb_pkg
interface srb_chan_if #(parameter type payload_t = logic);

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

### rtl/core/srb_bank.sv
// channel store: levels, due times, pending changes, master power flag
// holds the shared due-time comparator used by the tick scan; uses srb_pkg
module srb_bank #(
    parameter int CHANNELS = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  srb_pkg::bank_op_t op,
    output srb_pkg::bank_rd_t rd
);
    import srb_pkg::*;

    // only the first eight channels can ever be addressed or shown
    localparam int STORED = (CHANNELS < MAX_ADDR) ? CHANNELS : MAX_ADDR;
    localparam int IDX_W  = (STORED > 1) ? $clog2(STORED) : 1;

    logic              level_reg  [STORED];
    logic [TIME_W-1:0] due_reg    [STORED];
    logic [KIND_W-1:0] change_reg [STORED];
    logic              master_off_reg;

    logic [IDX_W-1:0]  addr;
    logic              fire;
    logic              fire_level;

    assign addr = op.idx[IDX_W-1:0];

    // shared compare: channel is due when its time is at or below now
    assign fire = (due_reg[addr] <= op.time_value);

    // level after a scheduled change fires
    always_comb
    begin
        case (change_reg[addr])
            CHANGE_OFF: fire_level = 1'b0;
            CHANGE_ON:  fire_level = 1'b1;
            default:    fire_level = ~level_reg[addr];
        endcase
    end

    // state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < STORED; c++)
            begin
                level_reg[c]  <= 1'b0;
                due_reg[c]    <= NO_DUE;
                change_reg[c] <= CHANGE_OFF;
            end
            master_off_reg <= 1'b0;
        end
        else
        begin
            case (op.op)
                OP_SET:
                begin
                    level_reg[addr] <= op.level;
                end
                OP_TOGGLE:
                begin
                    level_reg[addr] <= ~level_reg[addr];
                end
                OP_SCHEDULE:
                begin
                    due_reg[addr]    <= op.time_value;
                    change_reg[addr] <= op.kind;
                end
                OP_CANCEL:
                begin
                    due_reg[addr] <= NO_DUE;
                end
                OP_SCAN:
                begin
                    if (fire)
                    begin
                        due_reg[addr]   <= NO_DUE;
                        level_reg[addr] <= fire_level;
                    end
                end
                OP_POWER:
                begin
                    master_off_reg <= ~master_off_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    // driven pins, low while power is off
    for (genvar c = 0; c < PIN_W; c++)
    begin : g_pin
        if (c < STORED)
        begin : g_used
            assign rd.pins[c] = level_reg[c] & ~master_off_reg;
        end
        else
        begin : g_unused
            assign rd.pins[c] = 1'b0;
        end
    end

    // read port at the operation's channel
    assign rd.level      = level_reg[addr];
    assign rd.due_time   = due_reg[addr];
    assign rd.change     = change_reg[addr];
    assign rd.master_off = master_off_reg;

endmodule

### rtl/core/scheduled_relay_bank.sv
// scheduled relay bank: one item in, one result out per item
// an item passes from idle through the exec state, the scan state for a tick with power on, then the result state
// the result state holds until no result is held or the held result is taken
// the tick scan compares one channel due time per cycle on the shared comparator
// a new item is taken only in idle; the next item may enter while a result waits
// reset: levels low, due times all ones, pending changes off, power on, no result held
module scheduled_relay_bank #(
    parameter int CHANNELS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    srb_chan_if.sink          req,
    srb_chan_if.source        rsp
);
    import srb_pkg::*;

    localparam int STORED = (CHANNELS < MAX_ADDR) ? CHANNELS : MAX_ADDR;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_RESULT
    } state_t;

    state_t            state_reg, state_next;
    req_item_t         item_reg, item_next;
    logic [ADDR_W-1:0] scan_reg, scan_next;
    logic              acc_reg, acc_next;
    logic              out_valid_reg, out_valid_next;
    rsp_item_t         out_data_reg, out_data_next;

    bank_op_t          op;
    bank_rd_t          rd;
    logic              idx_valid;
    logic              scan_last;
    logic              out_free;

    srb_bank #(
        .CHANNELS (CHANNELS)
    ) u_bank (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op),
        .rd    (rd)
    );

    assign idx_valid = ({29'd0, item_reg.relay_index} < 32'(CHANNELS));
    assign scan_last = (scan_reg == ADDR_W'(STORED - 1));
    assign out_free  = ~out_valid_reg | rsp.ready;

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // operation issued to the channel store
    always_comb
    begin
        op.op         = OP_NONE;
        op.idx        = item_reg.relay_index;
        op.level      = item_reg.level;
        op.time_value = item_reg.time_value;
        op.kind       = item_reg.change_kind;
        case (state_reg)
            S_EXEC:
            begin
                case (item_reg.action)
                    ACT_SET:
                    begin
                        if (idx_valid && !rd.master_off)
                            op.op = OP_SET;
                    end
                    ACT_TOGGLE:
                    begin
                        if (idx_valid && !rd.master_off)
                            op.op = OP_TOGGLE;
                    end
                    ACT_SCHEDULE:
                    begin
                        if (idx_valid)
                            op.op = OP_SCHEDULE;
                    end
                    ACT_CANCEL:
                    begin
                        if (idx_valid)
                            op.op = OP_CANCEL;
                    end
                    ACT_POWER:
                    begin
                        op.op = OP_POWER;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_SCAN:
            begin
                op.op  = OP_SCAN;
                op.idx = scan_reg;
            end
            default:
            begin
            end
        endcase
    end

    // sequencer next state and result assembly
    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        scan_next      = scan_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (rsp.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    item_next  = req.data;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                acc_next = (item_reg.action inside {ACT_SET, ACT_TOGGLE})
                           && idx_valid && !rd.master_off;
                scan_next = '0;
                if ((item_reg.action == ACT_TICK) && !rd.master_off)
                    state_next = S_SCAN;
                else
                    state_next = S_RESULT;
            end
            S_SCAN:
            begin
                scan_next = scan_reg + 1'b1;
                if (scan_last)
                    state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.accepted      = acc_reg;
                    out_data_next.pin_levels    = rd.pins;
                    out_data_next.power_is_off  = rd.master_off;
                    if (idx_valid)
                    begin
                        out_data_next.queried_level    = rd.level & ~rd.master_off;
                        out_data_next.queried_due_time = rd.due_time;
                        out_data_next.queried_change   = rd.change;
                    end
                    else
                    begin
                        out_data_next.queried_level    = 1'b0;
                        out_data_next.queried_due_time = NO_DUE;
                        out_data_next.queried_change   = CHANGE_OFF;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_reg      <= '0;
            acc_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            item_reg      <= item_next;
            scan_reg      <= scan_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

endmodule

### tb/scheduled_relay_bank_tb.sv
// self-checking testbench for scheduled_relay_bank: directed table then random traffic
// depends on srb_pkg, srb_chan_if and the scheduled_relay_bank rtl
// results are checked against the directed table's expected values or an in-bench prediction of the channel store
module scheduled_relay_bank_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import srb_pkg::*;

    localparam int NCHAN = 8;
    localparam int MAX_GAP = 18;
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_ITEMS = 1500;

    // codes the package leaves unnamed
    localparam logic [2:0] ACT_NOP = 3'd7;
    localparam logic [KIND_W-1:0] CHANGE_FLIP = 2'd2;
    localparam logic [KIND_W-1:0] CHANGE_ODD  = 2'd3;

    typedef struct {
        req_item_t cmd;
        bit        typed;
        rsp_item_t want;
    } step_row_t;

    logic clk;
    logic rst_n;

    srb_chan_if #(.payload_t(req_item_t)) req_if ();
    srb_chan_if #(.payload_t(rsp_item_t)) rsp_if ();

    scheduled_relay_bank #(.CHANNELS(NCHAN)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // predicted channel store
    bit                chan_level [NCHAN];
    logic [TIME_W-1:0] chan_due   [NCHAN];
    logic [KIND_W-1:0] chan_kind  [NCHAN];
    bit                power_off;

    rsp_item_t   relay_status_q [$];
    step_row_t   directed_rows [$];
    int          fail_count;
    logic [31:0] wall_time;
    int          send_calm;
    int          take_calm;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // hard stop
    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // apply one action to the predicted store and return the status it reports
    function automatic rsp_item_t apply_relay_action(req_item_t it);
        rsp_item_t r;
        bit        in_range;
        int        c;
        r = '0;
        in_range = (int'(it.relay_index) < NCHAN);
        case (it.action)
            ACT_SET:
            begin
                if (in_range && !power_off)
                begin
                    chan_level[it.relay_index] = it.level;
                    r.accepted = 1'b1;
                end
            end
            ACT_TOGGLE:
            begin
                if (in_range && !power_off)
                begin
                    chan_level[it.relay_index] = !chan_level[it.relay_index];
                    r.accepted = 1'b1;
                end
            end
            ACT_SCHEDULE:
            begin
                if (in_range)
                begin
                    chan_due[it.relay_index] = it.time_value;
                    chan_kind[it.relay_index] = it.change_kind;
                end
            end
            ACT_CANCEL:
            begin
                if (in_range)
                    chan_due[it.relay_index] = NO_DUE;
            end
            ACT_TICK:
            begin
                // every channel due at or before now fires, nothing while off
                if (!power_off)
                begin
                    for (c = 0; c < NCHAN; c++)
                    begin
                        if (it.time_value >= chan_due[c])
                        begin
                            chan_due[c] = NO_DUE;
                            if (chan_kind[c] == CHANGE_OFF)
                                chan_level[c] = 1'b0;
                            else if (chan_kind[c] == CHANGE_ON)
                                chan_level[c] = 1'b1;
                            else
                                chan_level[c] = !chan_level[c];
                        end
                    end
                end
            end
            ACT_POWER:
                power_off = !power_off;
            default:
                ;
        endcase

        if (in_range)
        begin
            r.queried_level = power_off ? 1'b0 : chan_level[it.relay_index];
            r.queried_due_time = chan_due[it.relay_index];
            r.queried_change = chan_kind[it.relay_index];
        end
        else
        begin
            r.queried_due_time = NO_DUE;
        end
        for (c = 0; c < NCHAN && c < PIN_W; c++)
            r.pin_levels[c] = power_off ? 1'b0 : chan_level[c];
        r.power_is_off = power_off;
        return r;
    endfunction

    function automatic rsp_item_t mk_status(bit acc, bit lvl, logic [TIME_W-1:0] due,
                                            logic [KIND_W-1:0] chg, logic [PIN_W-1:0] pins,
                                            bit off);
        rsp_item_t r;
        r.accepted = acc;
        r.queried_level = lvl;
        r.queried_due_time = due;
        r.queried_change = chg;
        r.pin_levels = pins;
        r.power_is_off = off;
        return r;
    endfunction

    task automatic add_step(logic [2:0] a, logic [ADDR_W-1:0] idx, bit lv,
                            logic [TIME_W-1:0] t, logic [KIND_W-1:0] k,
                            bit typed = 1'b0, rsp_item_t want = '0);
        step_row_t row;
        row.cmd.action = a;
        row.cmd.relay_index = idx;
        row.cmd.level = lv;
        row.cmd.time_value = t;
        row.cmd.change_kind = k;
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endtask

    // idle cycles before the next item, with runs of back-to-back items
    function automatic int draw_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            calm = $urandom_range(5, 30);
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    // random traffic, weighted toward schedules and ticks that track a moving clock
    function automatic req_item_t random_action();
        req_item_t it;
        int        pick;
        int        tsel;
        it.action = ACT_NOP;
        it.relay_index = ADDR_W'($urandom_range(0, 7));
        it.level = 1'($urandom_range(0, 1));
        it.time_value = $urandom;
        it.change_kind = KIND_W'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        tsel = $urandom_range(0, 9);
        if (pick < 14)
            it.action = ACT_SET;
        else if (pick < 28)
            it.action = ACT_TOGGLE;
        else if (pick < 50)
        begin
            it.action = ACT_SCHEDULE;
            if (tsel == 1)
                it.time_value = ($urandom_range(0, 1) != 0) ? NO_DUE : '0;
            else if (tsel > 1)
                it.time_value = wall_time + $urandom_range(0, 120);
        end
        else if (pick < 58)
            it.action = ACT_CANCEL;
        else if (pick < 80)
        begin
            it.action = ACT_TICK;
            if (tsel == 1)
                it.time_value = NO_DUE;
            else if (tsel > 1)
            begin
                wall_time = wall_time + $urandom_range(0, 60);
                it.time_value = wall_time;
            end
        end
        else if (pick < 84)
            it.action = ACT_POWER;
        else if (pick < 96)
            it.action = ACT_QUERY;
        return it;
    endfunction

    // offer one item and wait for it to be taken
    task automatic send_item(req_item_t it, bit typed, rsp_item_t want);
        int        gap;
        rsp_item_t pred;
        gap = draw_gap(send_calm);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data <= it;
        do
            @(posedge clk);
        while (!req_if.ready);
        pred = apply_relay_action(it);
        relay_status_q.push_back(typed ? want : pred);
    endtask

    task automatic report_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        fail_count++;
        $display("%0t mismatch on %s: expected %h actual %h", $realtime, name, exp_v, act_v);
    endtask

    task automatic check_status(rsp_item_t got);
        rsp_item_t want;
        if (relay_status_q.size() == 0)
        begin
            fail_count++;
            $display("%0t unexpected result: expected none actual %h", $realtime, got);
            return;
        end
        want = relay_status_q.pop_front();
        if (got.accepted !== want.accepted)
            report_field("accepted", 32'(want.accepted), 32'(got.accepted));
        if (got.queried_level !== want.queried_level)
            report_field("queried_level", 32'(want.queried_level), 32'(got.queried_level));
        if (got.queried_due_time !== want.queried_due_time)
            report_field("queried_due_time", want.queried_due_time, got.queried_due_time);
        if (got.queried_change !== want.queried_change)
            report_field("queried_change", 32'(want.queried_change), 32'(got.queried_change));
        if (got.pin_levels !== want.pin_levels)
            report_field("pin_levels", 32'(want.pin_levels), 32'(got.pin_levels));
        if (got.power_is_off !== want.power_is_off)
            report_field("power_is_off", 32'(want.power_is_off), 32'(got.power_is_off));
    endtask

    // result side: random stalls, check every taken item
    initial
    begin
        int gap;
        rsp_if.ready <= 1'b0;
        take_calm = 0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            gap = draw_gap(take_calm);
            if (gap > 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_if.valid);
            check_status(rsp_if.data);
        end
    end

    // reset, directed table, random traffic, drain
    initial
    begin
        int c;
        int n;
        rst_n <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.data <= '0;
        fail_count = 0;
        send_calm = 0;
        wall_time = $urandom_range(0, 1000);
        power_off = 1'b0;
        for (c = 0; c < NCHAN; c++)
        begin
            chan_level[c] = 1'b0;
            chan_due[c] = NO_DUE;
            chan_kind[c] = CHANGE_OFF;
        end

        // reset state, extreme channels, firing, cancel, tick at all ones, power off
        add_step(ACT_QUERY, 3'd0, 1'b0, '0, '0, 1'b1,
                 mk_status(1'b0, 1'b0, NO_DUE, CHANGE_OFF, 8'h00, 1'b0));
        add_step(ACT_SET, 3'd7, 1'b1, '0, '0, 1'b1,
                 mk_status(1'b1, 1'b1, NO_DUE, CHANGE_OFF, 8'h80, 1'b0));
        add_step(ACT_SET, 3'd0, 1'b1, '0, '0, 1'b1,
                 mk_status(1'b1, 1'b1, NO_DUE, CHANGE_OFF, 8'h81, 1'b0));
        add_step(ACT_TOGGLE, 3'd7, 1'b0, '0, '0, 1'b1,
                 mk_status(1'b1, 1'b0, NO_DUE, CHANGE_OFF, 8'h01, 1'b0));
        add_step(ACT_SCHEDULE, 3'd3, 1'b0, 32'd0, CHANGE_ON, 1'b1,
                 mk_status(1'b0, 1'b0, 32'd0, CHANGE_ON, 8'h01, 1'b0));
        add_step(ACT_SCHEDULE, 3'd5, 1'b0, 32'hFFFF_FFFE, CHANGE_FLIP, 1'b1,
                 mk_status(1'b0, 1'b0, 32'hFFFF_FFFE, CHANGE_FLIP, 8'h01, 1'b0));
        add_step(ACT_SCHEDULE, 3'd6, 1'b0, 32'd100, CHANGE_ODD, 1'b1,
                 mk_status(1'b0, 1'b0, 32'd100, CHANGE_ODD, 8'h01, 1'b0));
        add_step(ACT_TICK, 3'd3, 1'b0, 32'd0, '0, 1'b1,
                 mk_status(1'b0, 1'b1, NO_DUE, CHANGE_ON, 8'h09, 1'b0));
        add_step(ACT_CANCEL, 3'd6, 1'b0, '0, '0, 1'b1,
                 mk_status(1'b0, 1'b0, NO_DUE, CHANGE_ODD, 8'h09, 1'b0));
        add_step(ACT_TICK, 3'd6, 1'b0, NO_DUE, '0, 1'b1,
                 mk_status(1'b0, 1'b1, NO_DUE, CHANGE_ODD, 8'h68, 1'b0));
        add_step(ACT_POWER, 3'd3, 1'b0, '0, '0, 1'b1,
                 mk_status(1'b0, 1'b0, NO_DUE, CHANGE_ON, 8'h00, 1'b1));
        add_step(ACT_SET, 3'd1, 1'b1, '0, '0, 1'b1,
                 mk_status(1'b0, 1'b0, NO_DUE, CHANGE_OFF, 8'h00, 1'b1));
        add_step(ACT_TOGGLE, 3'd2, 1'b0, '0, '0, 1'b1,
                 mk_status(1'b0, 1'b0, NO_DUE, CHANGE_OFF, 8'h00, 1'b1));
        add_step(ACT_SCHEDULE, 3'd1, 1'b0, 32'd5, CHANGE_ON, 1'b1,
                 mk_status(1'b0, 1'b0, 32'd5, CHANGE_ON, 8'h00, 1'b1));
        add_step(ACT_TICK, 3'd1, 1'b0, 32'd10, '0, 1'b1,
                 mk_status(1'b0, 1'b0, 32'd5, CHANGE_ON, 8'h00, 1'b1));
        add_step(ACT_QUERY, 3'd3, 1'b0, '0, '0, 1'b1,
                 mk_status(1'b0, 1'b0, NO_DUE, CHANGE_ON, 8'h00, 1'b1));
        add_step(ACT_POWER, 3'd3, 1'b0, '0, '0, 1'b1,
                 mk_status(1'b0, 1'b1, NO_DUE, CHANGE_ON, 8'h68, 1'b0));
        add_step(ACT_TICK, 3'd1, 1'b0, 32'd5, '0, 1'b1,
                 mk_status(1'b0, 1'b1, NO_DUE, CHANGE_ON, 8'h6A, 1'b0));
        add_step(ACT_NOP, 3'd5, 1'b0, '0, '0, 1'b1,
                 mk_status(1'b0, 1'b1, NO_DUE, CHANGE_FLIP, 8'h6A, 1'b0));
        // noisy unused fields, checked by prediction
        add_step(ACT_SET, 3'd4, 1'b0, NO_DUE, CHANGE_ODD);
        add_step(ACT_SCHEDULE, 3'd2, 1'b1, 32'hA5A5_5A5A, CHANGE_FLIP);
        add_step(ACT_SCHEDULE, 3'd0, 1'b1, 32'h5A5A_A5A5, CHANGE_ON);
        add_step(ACT_TICK, 3'd0, 1'b1, 32'hA5A5_5A5A, CHANGE_ODD);
        add_step(ACT_QUERY, 3'd2, 1'b1, 32'h0F0F_F0F0, CHANGE_ODD);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);

        for (n = 0; n < RANDOM_ITEMS; n++)
            send_item(random_action(), 1'b0, '0);
        req_if.valid <= 1'b0;

        // drain, then give the bank time to show any stray result
        while (relay_status_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### scheduled_relay_bank.f
rtl/core/srb_pkg.sv
rtl/core/srb_chan_if.sv
rtl/core/srb_bank.sv
rtl/core/scheduled_relay_bank.sv
tb/scheduled_relay_bank_tb.sv
